FILE: sv/xstr_pkg.sv
// Package for the x86 string instruction step block.
// Holds opcode, width and prefix codes, flag bit positions and word types.
// No dependencies.
package xstr_pkg;

  localparam logic [1:0] OpMovs = 2'd0;
  localparam logic [1:0] OpCmps = 2'd1;
  localparam logic [1:0] OpScas = 2'd2;
  localparam logic [1:0] OpStos = 2'd3;

  localparam logic [1:0] WidthByte = 2'd0;
  localparam logic [1:0] WidthWord = 2'd1;

  localparam logic [1:0] PreNone  = 2'd0;
  localparam logic [1:0] PreRep   = 2'd1;
  localparam logic [1:0] PreRepz  = 2'd2;
  localparam logic [1:0] PreRepnz = 2'd3;

  localparam int unsigned CfBit = 0;
  localparam int unsigned PfBit = 2;
  localparam int unsigned AfBit = 4;
  localparam int unsigned ZfBit = 6;
  localparam int unsigned SfBit = 7;
  localparam int unsigned DfBit = 10;
  localparam int unsigned OfBit = 11;

  localparam logic [31:0] ArithFlags = 32'h0000_08D5;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  width_code;
    logic [1:0]  prefix;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [31:0] count_in;
    logic [31:0] accumulator;
    logic [31:0] flags_in;
    logic [31:0] source_data;
    logic [31:0] dest_data;
  } in_word_t;

  typedef struct packed {
    logic [31:0] next_source_address;
    logic [31:0] next_dest_address;
    logic [31:0] next_count;
    logic [31:0] flags_out;
    logic        write_enable;
    logic [31:0] write_address;
    logic [31:0] write_data;
    logic        repeat_again;
    logic        performed;
  } out_word_t;

endpackage

FILE: sv/xstr_exec.sv
// Combinational execution of one string instruction step.
// Pointer steps, compare flags, store request and repeat decision.
// Depends on xstr_pkg.
module xstr_exec import xstr_pkg::*; (
  input  in_word_t  word_i,
  output out_word_t word_o
);

  logic [31:0] mask, sign, delta, size;
  logic [31:0] a, b, r;
  logic [32:0] diff;
  logic [31:0] cmp_flags;
  logic        is_cmp, skip, zf;

  always_comb begin
    unique case (word_i.width_code)
      WidthByte: begin
        size = 32'd1; mask = 32'h0000_00FF; sign = 32'h0000_0080;
      end
      WidthWord: begin
        size = 32'd2; mask = 32'h0000_FFFF; sign = 32'h0000_8000;
      end
      default: begin
        size = 32'd4; mask = 32'hFFFF_FFFF; sign = 32'h8000_0000;
      end
    endcase
    delta = word_i.flags_in[DfBit] ? (32'd0 - size) : size;
  end

  assign is_cmp = (word_i.opcode == OpCmps) || (word_i.opcode == OpScas);
  assign skip   = (word_i.prefix != PreNone) && (word_i.count_in == 32'd0);

  assign a    = ((word_i.opcode == OpCmps) ? word_i.source_data : word_i.accumulator) & mask;
  assign b    = word_i.dest_data & mask;
  assign diff = {1'b0, a} - {1'b0, b};
  assign r    = diff[31:0] & mask;
  assign zf   = (r == 32'd0);

  always_comb begin
    cmp_flags        = word_i.flags_in & ~ArithFlags;
    cmp_flags[CfBit] = diff[32];
    cmp_flags[PfBit] = ~^r[7:0];
    cmp_flags[AfBit] = a[4] ^ b[4] ^ r[4];
    cmp_flags[ZfBit] = zf;
    cmp_flags[SfBit] = |(r & sign);
    cmp_flags[OfBit] = |((a ^ b) & (a ^ r) & sign);
  end

  always_comb begin
    word_o.next_source_address = word_i.source_address;
    word_o.next_dest_address   = word_i.dest_address;
    word_o.next_count          = word_i.count_in;
    word_o.flags_out           = word_i.flags_in;
    word_o.write_enable        = 1'b0;
    word_o.write_address       = 32'd0;
    word_o.write_data          = 32'd0;
    word_o.repeat_again        = 1'b0;
    word_o.performed           = ~skip;
    if (!skip) begin
      word_o.next_dest_address = word_i.dest_address + delta;
      if ((word_i.opcode == OpMovs) || (word_i.opcode == OpCmps)) begin
        word_o.next_source_address = word_i.source_address + delta;
      end
      if (is_cmp) begin
        word_o.flags_out = cmp_flags;
      end else begin
        word_o.write_enable  = 1'b1;
        word_o.write_address = word_i.dest_address;
        word_o.write_data    = ((word_i.opcode == OpMovs) ? word_i.source_data
                                                          : word_i.accumulator) & mask;
      end
      if (word_i.prefix != PreNone) begin
        word_o.next_count = word_i.count_in - 32'd1;
        if (!is_cmp) begin
          word_o.repeat_again = 1'b1;
        end else if (word_i.prefix == PreRepnz) begin
          word_o.repeat_again = ~zf;
        end else begin
          word_o.repeat_again = zf;
        end
      end
    end
  end

endmodule

FILE: sv/x86_string_instruction_step.sv
// x86 string instruction step: MOVS, CMPS, SCAS, STOS with repeat prefixes.
// Path from accepted input word to result word: input register, execution
// logic, result register; throughput one word per cycle when not stalled.
// Reset clears both stage valid bits; payload registers are not reset.
// Depends on xstr_pkg and xstr_exec.
module x86_string_instruction_step import xstr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic      s1_valid_q, s2_valid_q;
  in_word_t  s1_q;
  out_word_t s2_q, s2_d;
  logic      s2_ready, s1_ready;

  assign s2_ready   = ~s2_valid_q | ~out_stall_i;
  assign s1_ready   = ~s1_valid_q | s2_ready;
  assign in_stall_o = ~s1_ready;

  xstr_exec u_exec (
    .word_i (s1_q),
    .word_o (s2_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) s1_q <= in_word_i;
    if (s2_ready && s1_valid_q) s2_q <= s2_d;
  end

  assign out_valid_o = s2_valid_q;
  assign out_word_o  = s2_q;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s2_valid_q && out_stall_i))
    else $error("input stalled without a full pipeline");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_ready) |=> (s1_valid_q && $stable(s1_q)))
    else $error("held input word lost");

  a_skip_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.performed)
      |-> (!out_word_o.write_enable && !out_word_o.repeat_again))
    else $error("skipped step produced a store or repeat");

  a_plain_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (s1_q.prefix == PreNone))
      |-> (s2_d.performed && !s2_d.repeat_again && (s2_d.next_count == s1_q.count_in)))
    else $error("unprefixed step repeated or changed the count");

endmodule

FILE: dv/tb_x86_string_instruction_step.sv
// Testbench for x86_string_instruction_step: drives string instruction steps and
// checks each result word against an in-bench predictor of MOVS, CMPS, SCAS, STOS.
// Depends on xstr_pkg and the block's RTL.
module tb_x86_string_instruction_step;
  import xstr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] WidthDword = 2'd2;
  localparam logic [1:0] WidthRsvd  = 2'd3;
  localparam int         StallLimit = 4000;
  localparam int         HoldCycles = 300;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  out_word_t step_results_q[$];
  int        mismatches    = 0;
  int        src_idle_pct  = 0;
  int        sink_idle_pct = 0;
  int        hold_req      = 0;
  int        hold_left     = 0;
  int        quiet_cycles  = 0;

  x86_string_instruction_step u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [31:0] operand_mask(logic [1:0] wc);
    case (wc)
      WidthByte: return 32'h0000_00FF;
      WidthWord: return 32'h0000_FFFF;
      default:   return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic out_word_t step_model(in_word_t w);
    out_word_t   r;
    logic [31:0] mask, sign, delta, a, b, diff, fl;
    logic        is_cmp, zf;
    mask   = operand_mask(w.width_code);
    sign   = mask ^ (mask >> 1);
    delta  = (mask == 32'h0000_00FF) ? 32'd1 : (mask == 32'h0000_FFFF) ? 32'd2 : 32'd4;
    if (w.flags_in[DfBit]) delta = -delta;
    is_cmp = (w.opcode == OpCmps) || (w.opcode == OpScas);
    r = '0;
    r.next_source_address = w.source_address;
    r.next_dest_address   = w.dest_address;
    r.next_count          = w.count_in;
    r.flags_out           = w.flags_in;
    if (w.prefix != PreNone && w.count_in == '0) return r;
    r.performed = 1'b1;
    r.next_dest_address = w.dest_address + delta;
    if (w.opcode == OpMovs || w.opcode == OpCmps)
      r.next_source_address = w.source_address + delta;
    if (!is_cmp) begin
      r.write_enable  = 1'b1;
      r.write_address = w.dest_address;
      r.write_data    = ((w.opcode == OpMovs) ? w.source_data : w.accumulator) & mask;
    end else begin
      a    = ((w.opcode == OpCmps) ? w.source_data : w.accumulator) & mask;
      b    = w.dest_data & mask;
      diff = (a - b) & mask;
      fl   = w.flags_in & ~ArithFlags;
      fl[CfBit] = b > a;
      fl[PfBit] = ~^diff[7:0];
      fl[AfBit] = a[4] ^ b[4] ^ diff[4];
      fl[ZfBit] = diff == '0;
      fl[SfBit] = |(diff & sign);
      fl[OfBit] = |((a ^ b) & (a ^ diff) & sign);
      r.flags_out = fl;
    end
    if (w.prefix != PreNone) begin
      r.next_count = w.count_in - 32'd1;
      zf = r.flags_out[ZfBit];
      if (!is_cmp) r.repeat_again = 1'b1;
      else if (w.prefix == PreRepnz) r.repeat_again = !zf;
      else r.repeat_again = zf;
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000 >> (8 * $urandom_range(3));
      3:       return 32'($urandom_range(255));
      default: return $urandom;
    endcase
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    w.opcode         = 2'($urandom_range(3));
    w.width_code     = 2'($urandom_range(3));
    w.prefix         = 2'($urandom_range(3));
    w.source_address = rand_value();
    w.dest_address   = rand_value();
    w.count_in       = rand_value();
    w.accumulator    = rand_value();
    w.flags_in       = $urandom;
    w.source_data    = rand_value();
    w.dest_data      = rand_value();
    return w;
  endfunction

  function automatic in_word_t make_word(logic [1:0] op, logic [1:0] wc, logic [1:0] pre,
                                         logic [31:0] esi, logic [31:0] edi, logic [31:0] ecx,
                                         logic [31:0] eax, logic [31:0] fl, logic [31:0] sd,
                                         logic [31:0] dd);
    return '{op, wc, pre, esi, edi, ecx, eax, fl, sd, dd};
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    step_results_q.push_back(step_model(w));
    @(negedge clk_i);
  endtask

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%t %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("mismatch %s: expected %h, got %h", name, want, got));
  endtask

  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (step_results_q.size() == 0) begin
        flag_error($sformatf("result word with nothing outstanding: %p", out_word_o));
      end else begin
        want = step_results_q.pop_front();
        check_field("next_source_address", out_word_o.next_source_address,
                    want.next_source_address);
        check_field("next_dest_address", out_word_o.next_dest_address, want.next_dest_address);
        check_field("next_count", out_word_o.next_count, want.next_count);
        check_field("flags_out", out_word_o.flags_out, want.flags_out);
        check_field("write_enable", 32'(out_word_o.write_enable), 32'(want.write_enable));
        check_field("write_address", out_word_o.write_address, want.write_address);
        check_field("write_data", out_word_o.write_data, want.write_data);
        check_field("repeat_again", 32'(out_word_o.repeat_again), 32'(want.repeat_again));
        check_field("performed", 32'(out_word_o.performed), 32'(want.performed));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("timeout: no word moved for %0d cycles", StallLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_directed();
    in_word_t w;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    // every opcode against every width code, prefix set to width code xor opcode, extremes in the fields
    for (int op = 0; op < 4; op++) begin
      for (int wc = 0; wc < 4; wc++) begin
        w = make_word(2'(op), 2'(wc), 2'(wc ^ op),
                      (wc % 2) ? '1 : '0, (wc % 2) ? '0 : '1,
                      (op % 2) ? 32'd1 : '1,
                      (wc < 2) ? 32'h8000_0000 : '1,
                      ((op + wc) % 2) ? '1 : '0,
                      (op < 2) ? '1 : 32'h8080_8080,
                      (op < 2) ? 32'h7F7F_7F7F : '0);
        send_word(w);
      end
    end
    // zero count under rep and repnz, none with zero count still runs
    send_word(make_word(OpMovs, WidthDword, PreRep, 32'h100, 32'h200, '0, '1, '0, '1, '1));
    send_word(make_word(OpCmps, WidthByte, PreRepnz, 32'h10, 32'h20, '0, '0, '1, 32'h5, 32'h5));
    send_word(make_word(OpScas, WidthWord, PreNone, 32'h10, 32'h20, '0, 32'h1234, '0, '0,
                        32'h1234));
    // repz and repnz on equal operands, rep on compare acting as repz
    send_word(make_word(OpCmps, WidthByte, PreRepz, 32'h40, 32'h80, 32'd5, '0, '0,
                        32'hAA55, 32'h1255));
    send_word(make_word(OpCmps, WidthByte, PreRepnz, 32'h40, 32'h80, 32'd5, '0, '0,
                        32'h55, 32'h55));
    send_word(make_word(OpScas, WidthDword, PreRep, 32'h40, 32'h80, 32'd3, 32'd7, '0, '0,
                        32'd9));
    // rep stos with count one still asks to repeat
    send_word(make_word(OpStos, WidthRsvd, PreRep, 32'h0, 32'hFFFF_FFFE, 32'd1, 32'hCAFE_F00D,
                        32'h400, '0, '0));
    // signed overflow on a byte compare, pointers wrapping below zero
    send_word(make_word(OpCmps, WidthByte, PreNone, '0, '0, 32'd2, '0, 32'h400, 32'h80, 32'h01));
  endtask

  task automatic test_string_runs(input int src_pct, input int sink_pct, input int n_items);
    in_word_t    w;
    out_word_t   r;
    logic [31:0] mask;
    int          sent, steps;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    sent = 0;
    while (sent < n_items) begin
      w = rand_word();
      if ($urandom_range(3) == 0) begin
        send_word(w);
        sent++;
      end else begin
        // a repeated instruction of up to 12 steps, each step fed from the one before
        if ($urandom_range(7) != 0) w.count_in = 32'($urandom_range(6));
        if (w.prefix == PreNone && $urandom_range(1)) w.prefix = PreRep;
        mask  = operand_mask(w.width_code);
        steps = 0;
        do begin
          w.source_data = rand_value();
          w.dest_data   = rand_value();
          if ($urandom_range(1))
            w.dest_data = (((w.opcode == OpScas) ? w.accumulator : w.source_data) & mask)
                          | ($urandom & ~mask);
          r = step_model(w);
          send_word(w);
          sent++;
          steps++;
          w.source_address = r.next_source_address;
          w.dest_address   = r.next_dest_address;
          w.count_in       = r.next_count;
          w.flags_in       = r.flags_out;
        end while (r.repeat_again && steps < 12);
      end
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_req      = HoldCycles;
    repeat (40) send_word(rand_word());
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_string_runs(32, 50, 400);
    test_string_runs(50, 32, 400);
    test_string_runs(0, 0, 400);
    test_backpressure();
    in_valid_i <= 1'b0;
    while (step_results_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && step_results_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
